[src/spg_pkg.sv]
// ----------------------------------------------------------------------------
// spg_pkg
// Shared constants, types and helpers of the spectrum peak gate smoother.
// ----------------------------------------------------------------------------
package spg_pkg;

   localparam int MAX_BINS    = 1024;
   localparam int SAMPLE_BITS = 24;

   localparam int IDX_W  = $clog2(MAX_BINS);        // bin position
   localparam int LEN_W  = IDX_W + 1;               // frame length, up to MAX_BINS
   localparam int POS_W  = IDX_W + 2;               // position arithmetic with headroom
   localparam int ADDR_W = IDX_W + 1;               // bank bit and position
   localparam int VAL_W  = SAMPLE_BITS + 2;         // quarter units

   localparam int WIN    = 7;                       // peak marks around a bin
   localparam int REACH  = 3;                       // gate distance

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(129);
   localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_BINS);

   // one classified bin handed from front to back
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] amplitude;
      logic [IDX_W-1:0]       bin;
      logic [LEN_W-1:0]       len;
      logic                   bank;
      logic                   full_frame;
      logic                   last;
      logic                   peak_prev;
      logic                   peak_last;
   } cmd_type;

   // peak summary of one bank
   typedef struct packed {
      logic [1:0]       count;
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] final_pos;
   } peak_sum_type;

   // record one peak at a position
   function automatic peak_sum_type add_peak(peak_sum_type s, logic [IDX_W-1:0] pos);
      peak_sum_type r;
      r = s;
      if (s.count == 2'd0) r.first = pos;
      r.final_pos = pos;
      if (s.count != 2'd2) r.count = s.count + 2'd1;
      return r;
   endfunction

endpackage

[src/spg_if.sv]
// ----------------------------------------------------------------------------
// spg_req_if / spg_rsp_if
// Valid/ready channels for incoming bins and outgoing smoothed bins.
// ----------------------------------------------------------------------------
interface spg_req_if;
   logic                            valid;
   logic                            ready;
   logic [spg_pkg::SAMPLE_BITS-1:0] amplitude;

   modport source (output valid, output amplitude, input ready);
   modport sink (input valid, input amplitude, output ready);
endinterface

interface spg_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [spg_pkg::VAL_W-1:0] smoothed_value;
   logic [spg_pkg::IDX_W-1:0] bin_index;
   logic                      frame_valid;
   logic                      last_bin;

   modport source (output valid, output smoothed_value, output bin_index,
                   output frame_valid, output last_bin, input ready);
   modport sink (input valid, input smoothed_value, input bin_index,
                 input frame_valid, input last_bin, output ready);
endinterface

[src/spg_front.sv]
// ----------------------------------------------------------------------------
// spg_front
// Accepts bins, tracks frame position and bank, detects local maxima.
// ----------------------------------------------------------------------------
module spg_front (
   input  logic                         clock,
   input  logic                         reset,
   spg_req_if.sink                      req,
   input  logic                         csr_write_enable,
   input  logic [spg_pkg::LEN_W-1:0]    csr_write_data,
   output logic                         push_valid,
   input  logic                         push_ready,
   output spg_pkg::cmd_type             push_data
);

   logic [spg_pkg::LEN_W-1:0]       length_ff;
   logic [spg_pkg::IDX_W-1:0]       counter_ff, counter_in;
   logic                            bank_ff, bank_in;
   logic                            full_ff, full_in;
   logic [spg_pkg::SAMPLE_BITS-1:0] prior0_ff, prior0_in;
   logic [spg_pkg::SAMPLE_BITS-1:0] prior1_ff, prior1_in;

   logic [spg_pkg::LEN_W-1:0] len;
   logic [spg_pkg::IDX_W-1:0] pos;
   logic                      is_last;
   logic                      accept;

   // clamp the configured length
   always_comb begin
      len = length_ff;
      if (length_ff < spg_pkg::LEN_MIN) len = spg_pkg::LEN_MIN;
      if (length_ff > spg_pkg::LEN_MAX) len = spg_pkg::LEN_MAX;
   end

   // position, restarting if the length shrank below it
   assign pos     = ({1'b0, counter_ff} >= len) ? '0 : counter_ff;
   assign is_last = ({1'b0, pos} == len - spg_pkg::LEN_W'(1));

   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign accept     = req.valid && push_ready;

   // classify the transaction
   always_comb begin
      push_data            = '0;
      push_data.amplitude  = req.amplitude;
      push_data.bin        = pos;
      push_data.len        = len;
      push_data.bank       = bank_ff;
      push_data.full_frame = full_ff;
      push_data.last       = is_last;
      if (pos == spg_pkg::IDX_W'(1))
         push_data.peak_prev = prior0_ff > req.amplitude;
      else if (pos >= spg_pkg::IDX_W'(2))
         push_data.peak_prev = (prior0_ff > prior1_ff) && (prior0_ff >= req.amplitude);
      push_data.peak_last = is_last && (req.amplitude > prior0_ff);
   end

   // frame tracking
   always_comb begin
      counter_in = counter_ff;
      bank_in    = bank_ff;
      full_in    = full_ff;
      prior0_in  = prior0_ff;
      prior1_in  = prior1_ff;
      if (accept) begin
         prior1_in = prior0_ff;
         prior0_in = req.amplitude;
         if (is_last) begin
            counter_in = '0;
            bank_in    = !bank_ff;
            full_in    = 1'b1;
         end else begin
            counter_in = pos + spg_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff  <= spg_pkg::LEN_RESET;
         counter_ff <= '0;
         bank_ff    <= 1'b0;
         full_ff    <= 1'b0;
         prior0_ff  <= '0;
         prior1_ff  <= '0;
      end else begin
         if (csr_write_enable) length_ff <= csr_write_data;
         counter_ff <= counter_in;
         bank_ff    <= bank_in;
         full_ff    <= full_in;
         prior0_ff  <= prior0_in;
         prior1_ff  <= prior1_in;
      end
   end

endmodule

[src/spg_queue.sv]
// ----------------------------------------------------------------------------
// spg_queue
// Two-entry queue of classified bins between front and back.
// ----------------------------------------------------------------------------
module spg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  spg_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output spg_pkg::cmd_type pop_data
);

   spg_pkg::cmd_type slot_ff [2];
   logic             wr_ff, rd_ff;
   logic [1:0]       fill_ff;
   logic             push, pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   // pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         if (push && !pop) fill_ff <= fill_ff + 2'd1;
         else if (pop && !push) fill_ff <= fill_ff - 2'd1;
      end
   end

endmodule

[src/spg_back.sv]
// ----------------------------------------------------------------------------
// spg_back
// Holds the two banks, gates and smooths the previous frame, stores the new bin.
// ----------------------------------------------------------------------------
module spg_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  spg_pkg::cmd_type pop_data,
   spg_rsp_if.source        rsp
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_READ    = 5'b00010,
      S_WRITE_A = 5'b00100,
      S_WRITE_B = 5'b01000,
      S_EMIT    = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   spg_pkg::cmd_type cmd_ff;

   // bank memories
   logic [spg_pkg::SAMPLE_BITS-1:0] store_mem [2*spg_pkg::MAX_BINS];
   logic                            mark_mem  [2*spg_pkg::MAX_BINS];
   logic [spg_pkg::SAMPLE_BITS-1:0] store_q_ff;
   logic                            mark_q_ff;
   logic                            kval_ff;
   logic [spg_pkg::ADDR_W-1:0]      raddr;
   logic                            kval;
   logic                            store_we, mark_we, mark_wd;
   logic [spg_pkg::ADDR_W-1:0]      store_wa, mark_wa;

   logic [spg_pkg::WIN-1:0]         mark_win_ff;
   logic [spg_pkg::SAMPLE_BITS-1:0] store_win_ff [3];

   spg_pkg::peak_sum_type sum_ff [2];
   spg_pkg::peak_sum_type sum_new, sum_prev;

   logic [spg_pkg::VAL_W-1:0] res_ff;
   logic                      rsp_valid_ff;
   logic [spg_pkg::VAL_W-1:0] val_ff;
   logic [spg_pkg::IDX_W-1:0] idx_ff;
   logic                      fv_ff, lb_ff;

   logic [spg_pkg::POS_W-1:0] c_w, len_w, kb;
   logic [spg_pkg::IDX_W-1:0] c_m1;
   logic                      capture;
   logic [spg_pkg::SAMPLE_BITS-1:0] g [3];
   logic [spg_pkg::VAL_W-1:0] result;

   assign c_w   = spg_pkg::POS_W'(cmd_ff.bin);
   assign len_w = spg_pkg::POS_W'(cmd_ff.len);
   assign c_m1  = cmd_ff.bin - spg_pkg::IDX_W'(1);

   // neighbourhood read address, biased by the gate distance
   assign kb      = c_w + spg_pkg::POS_W'(step_ff);
   assign kval    = (kb >= spg_pkg::POS_W'(spg_pkg::REACH)) &&
                    (kb - spg_pkg::POS_W'(spg_pkg::REACH) < len_w);
   assign raddr   = {!cmd_ff.bank,
                     spg_pkg::IDX_W'(kb - spg_pkg::POS_W'(spg_pkg::REACH))};
   assign capture = (state_ff == S_READ) && (step_ff != 3'd0);

   // memory ports
   always_ff @(posedge clock) begin
      store_q_ff <= store_mem[raddr];
      mark_q_ff  <= mark_mem[raddr];
      if (store_we) store_mem[store_wa] <= cmd_ff.amplitude;
      if (mark_we) mark_mem[mark_wa] <= mark_wd;
   end

   // write port control
   always_comb begin
      store_we = (state_ff == S_WRITE_A);
      store_wa = {cmd_ff.bank, cmd_ff.bin};
      mark_we  = 1'b0;
      mark_wa  = {cmd_ff.bank, cmd_ff.bin};
      mark_wd  = 1'b0;
      if (state_ff == S_WRITE_A) begin
         mark_we = 1'b1;
         mark_wd = cmd_ff.peak_last;
      end else if (state_ff == S_WRITE_B) begin
         mark_we = cmd_ff.peak_prev;
         mark_wa = {cmd_ff.bank, c_m1};
         mark_wd = 1'b1;
      end
   end

   // neighbourhood windows
   always_ff @(posedge clock) begin
      kval_ff <= kval;
      if (capture) begin
         mark_win_ff <= {mark_win_ff[spg_pkg::WIN-2:0], mark_q_ff && kval_ff};
         if (step_ff >= 3'd3 && step_ff <= 3'd5) begin
            store_win_ff[2] <= store_win_ff[1];
            store_win_ff[1] <= store_win_ff[0];
            store_win_ff[0] <= store_q_ff;
         end
      end
   end

   // gate for the three bins around the current position
   always_comb begin
      logic [spg_pkg::POS_W-1:0] j, p, q;
      logic                      jv, zero, near;
      p = spg_pkg::POS_W'(sum_ff[!cmd_ff.bank].first);
      q = spg_pkg::POS_W'(sum_ff[!cmd_ff.bank].final_pos);
      for (int d = 0; d < 3; d++) begin
         j    = c_w + spg_pkg::POS_W'(d) - spg_pkg::POS_W'(1);
         jv   = 1'b1;
         if (d == 0) jv = (cmd_ff.bin != '0);
         if (d == 2) jv = (j < len_w);
         near = |mark_win_ff[6-d -: 5];
         unique case (sum_ff[!cmd_ff.bank].count)
            2'd0:    zero = 1'b0;
            2'd1:    zero = (j + spg_pkg::POS_W'(spg_pkg::REACH) <= p) ||
                            (j >= p + spg_pkg::POS_W'(spg_pkg::REACH));
            default: zero = (p + spg_pkg::POS_W'(spg_pkg::REACH) <= j) &&
                            (j + spg_pkg::POS_W'(spg_pkg::REACH) <= q) && !near;
         endcase
         g[d] = (jv && !zero) ? store_win_ff[2-d] : '0;
      end
   end

   // smoother
   always_comb begin
      if (!cmd_ff.full_frame)
         result = '0;
      else if (cmd_ff.last)
         result = {g[1], 2'b00};
      else
         result = spg_pkg::VAL_W'(g[0]) + {1'b0, g[1], 1'b0} + spg_pkg::VAL_W'(g[2]);
   end

   // peak summary update of the bank being loaded
   always_comb begin
      sum_prev = sum_ff[cmd_ff.bank];
      if (cmd_ff.bin == '0) sum_prev.count = 2'd0;
      sum_new = sum_prev;
      if (cmd_ff.peak_prev) sum_new = spg_pkg::add_peak(sum_new, c_m1);
      if (cmd_ff.peak_last) sum_new = spg_pkg::add_peak(sum_new, cmd_ff.bin);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      pop_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            pop_ready = 1'b1;
            step_in   = '0;
            if (pop_valid) state_in = S_READ;
         end
         S_READ: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) state_in = S_WRITE_A;
         end
         S_WRITE_A: state_in = S_WRITE_B;
         S_WRITE_B: state_in = S_EMIT;
         S_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && pop_valid) cmd_ff <= pop_data;
      if (state_ff == S_WRITE_A) res_ff <= result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         sum_ff[0] <= '0;
         sum_ff[1] <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (state_ff == S_WRITE_A) sum_ff[cmd_ff.bank] <= sum_new;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_EMIT && (!rsp_valid_ff || rsp.ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EMIT && (!rsp_valid_ff || rsp.ready)) begin
         val_ff <= res_ff;
         idx_ff <= cmd_ff.bin;
         fv_ff  <= cmd_ff.full_frame;
         lb_ff  <= cmd_ff.full_frame && cmd_ff.last;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.smoothed_value = val_ff;
   assign rsp.bin_index      = idx_ff;
   assign rsp.frame_valid    = fv_ff;
   assign rsp.last_bin       = lb_ff;

endmodule

[src/spectrum_peak_gate_smoother.sv]
// ----------------------------------------------------------------------------
// spectrum_peak_gate_smoother
// Peak-gated [1,2,1] smoothing of amplitude spectra through ping-pong banks.
// ----------------------------------------------------------------------------
// Each transaction loads one bin of the current frame and returns one bin of
// the previous frame, gated around its peaks and smoothed, in quarter units.
// A transaction passes through the back end in steps: the idle state takes it
// from the queue, the read state reads the seven-bin neighbourhood of the
// emitted bin one entry per cycle through one read address shared by the bank
// memories (read data are registered), the states WRITE_A and WRITE_B store the
// new bin and its peak marks, and the emit state hands the result to the output
// register. A stalled result side holds the back end in the emit state.
// A two-entry queue lets the front keep accepting while the back end works.
// ----------------------------------------------------------------------------
module spectrum_peak_gate_smoother (
   input  logic                      clock,
   input  logic                      reset,
   spg_req_if.sink                   req_bus,
   spg_rsp_if.source                 rsp_bus,
   input  logic                      csr_write_enable,
   input  logic [spg_pkg::LEN_W-1:0] csr_write_data
);

   logic             push_valid, push_ready, pop_valid, pop_ready;
   spg_pkg::cmd_type push_data, pop_data;

   // classification
   spg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   // decoupling queue
   spg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // gating, smoothing and bank update
   spg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_bus)
   );

endmodule
